// File: hw/rtl/psc_pkg.sv
// Shared types and character codes for the pattern syntax checker.
`timescale 1ns / 1ps

package psc_pkg;

  // Largest nesting depth accepted by default for either bracket kind.
  localparam int unsigned DEPTH_MAX_DEF = 255;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_FF     = 8'hFF;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_QUEST  = 8'h3F;
  localparam logic [7:0] CH_LSQ    = 8'h5B;
  localparam logic [7:0] CH_RSQ    = 8'h5D;
  localparam logic [7:0] CH_LPAR   = 8'h28;
  localparam logic [7:0] CH_RPAR   = 8'h29;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  // One input word as held in the input register.
  typedef struct packed {
    logic [7:0] char_in;
    logic       is_last;
  } psc_item_t;

endpackage

// File: hw/rtl/psc_in_reg.sv
// Input register stage of the pattern syntax checker.
`timescale 1ns / 1ps

module psc_in_reg
  import psc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  psc_item_t in_item,
  output logic      hold_valid,
  output psc_item_t hold_item,
  input  logic      take
);

  logic      valid_r;
  logic      valid_nxt;
  psc_item_t item_r;

  // The register can load whenever it is empty or its word leaves this cycle.
  assign in_ready  = !valid_r || take;
  assign valid_nxt = in_valid || (valid_r && !take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign hold_valid = valid_r;
  assign hold_item  = item_r;

endmodule

// File: hw/rtl/psc_core.sv
// Per-string syntax state and its combinational next-state update.
`timescale 1ns / 1ps

module psc_core
  import psc_pkg::*;
#(
  parameter int unsigned DEPTH_MAX = DEPTH_MAX_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      take,
  input  psc_item_t item,
  output logic      verdict
);

  localparam int unsigned DW = $clog2(DEPTH_MAX + 1);
  localparam logic [DW-1:0] DMAX = DW'(DEPTH_MAX);

  logic [DW-1:0] sq_r, sq_nxt, rd_r, rd_nxt;
  logic          esc_r, esc_nxt;
  logic [7:0]    prev_r, prev_nxt;
  logic          have_prev_r, have_prev_nxt;
  logic          failed_r, failed_nxt;
  logic          start_r, start_nxt;

  logic [7:0] c;
  logic       last;
  logic       is_quant;
  logic       lone_special;

  assign c    = item.char_in;
  assign last = item.is_last;
  assign is_quant = (c == CH_STAR) || (c == CH_PLUS) || (c == CH_QUEST);
  assign lone_special = is_quant || (c == CH_DOLLAR) || (c == CH_LSQ) || (c == CH_RSQ);

  always_comb begin
    sq_nxt        = sq_r;
    rd_nxt        = rd_r;
    esc_nxt       = esc_r;
    prev_nxt      = prev_r;
    have_prev_nxt = have_prev_r;
    failed_nxt    = failed_r;
    start_nxt     = 1'b0;

    if ((c == CH_NUL) || (c == CH_FF)) begin
      failed_nxt = 1'b1;
    end
    if (start_r && last && lone_special) begin
      failed_nxt = 1'b1;
    end

    if (esc_r) begin
      esc_nxt = 1'b0;
    end else if ((c == CH_BSLASH) && !last) begin
      esc_nxt = 1'b1;
    end else begin
      // Opens saturate at the limit and closes stop at zero, both failing.
      if (c == CH_LSQ) begin
        if (sq_r >= DMAX) failed_nxt = 1'b1;
        else              sq_nxt = sq_r + 1'b1;
      end else if (c == CH_RSQ) begin
        if (sq_r == '0) failed_nxt = 1'b1;
        else            sq_nxt = sq_r - 1'b1;
      end else if (c == CH_LPAR) begin
        if (rd_r >= DMAX) failed_nxt = 1'b1;
        else              rd_nxt = rd_r + 1'b1;
      end else if (c == CH_RPAR) begin
        if (rd_r == '0) failed_nxt = 1'b1;
        else            rd_nxt = rd_r - 1'b1;
      end
      if (is_quant && (!have_prev_r || (prev_r != CH_RPAR))) begin
        failed_nxt = 1'b1;
      end
    end

    if ((c != CH_SPACE) && (c != CH_TAB)) begin
      prev_nxt      = c;
      have_prev_nxt = 1'b1;
    end
  end

  assign verdict = !failed_nxt && (sq_nxt == '0) && (rd_nxt == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_r        <= '0;
      rd_r        <= '0;
      esc_r       <= 1'b0;
      prev_r      <= '0;
      have_prev_r <= 1'b0;
      failed_r    <= 1'b0;
      start_r     <= 1'b1;
    end else if (take) begin
      if (last) begin
        // The final word closes the string: back to the idle state.
        sq_r        <= '0;
        rd_r        <= '0;
        esc_r       <= 1'b0;
        prev_r      <= '0;
        have_prev_r <= 1'b0;
        failed_r    <= 1'b0;
        start_r     <= 1'b1;
      end else begin
        sq_r        <= sq_nxt;
        rd_r        <= rd_nxt;
        esc_r       <= esc_nxt;
        prev_r      <= prev_nxt;
        have_prev_r <= have_prev_nxt;
        failed_r    <= failed_nxt;
        start_r     <= start_nxt;
      end
    end
  end

endmodule

// File: hw/rtl/pattern_syntax_checker_unit.sv
// Top level of the pattern syntax checker: input register, checker state and result register.
`timescale 1ns / 1ps
// A word is registered on acceptance; a final word's verdict enters the result register when
// the checker takes it. The state update is a single pass of counters and compares.
// Throughput: one word per cycle, but a final word waits while the result register is full.
// Reset: rst_n is synchronous and active low; it empties both registers and returns the
// checker to the start of a new string.

module pattern_syntax_checker_unit
  import psc_pkg::*;
#(
  parameter int unsigned DEPTH_MAX = DEPTH_MAX_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] char_in
  input  logic       in_tlast,   // is_last
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // [0] valid_res, [7:1] zero
);

  psc_item_t in_item;
  psc_item_t hold_item;
  logic      hold_valid;
  logic      take;
  logic      verdict;
  logic      out_valid_r, out_valid_nxt;
  logic      out_res_r;
  logic      out_free;

  assign in_item.char_in = in_tdata;
  assign in_item.is_last = in_tlast;

  // Input register: decouples the upstream handshake from the checker.
  psc_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .hold_valid (hold_valid),
    .hold_item  (hold_item),
    .take       (take)
  );

  // The output register is free when empty or when its word is taken this cycle.
  assign out_free = !out_valid_r || out_tready;

  // A word that is not the last of its string produces no result, so it only needs the
  // checker to advance; a final word also needs room in the result register.
  assign take = hold_valid && (!hold_item.is_last || out_free);

  psc_core #(
    .DEPTH_MAX (DEPTH_MAX)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .item    (hold_item),
    .verdict (verdict)
  );

  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    if (take && hold_item.is_last) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && hold_item.is_last) begin
      out_res_r <= verdict;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_res_r};

  // A final word that leaves the input register always lands in the result register.
  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (take && hold_item.is_last) |=> out_tvalid)
    else $error("final word did not produce a result");

  // A word that is not final never creates a result on its own.
  a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
    (!(take && hold_item.is_last) && !(out_tvalid && !out_tready)) |=> !out_tvalid)
    else $error("result appeared without a final word");

  // A pending final word never waits while the result register is free.
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (hold_valid && out_free) |-> take)
    else $error("input register stalled with a free output");

  // Reset leaves the result register empty.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

// File: dv/psc_verdict_checker.sv
// Watches both streams of the pattern syntax checker, predicts each verdict and compares it.
`timescale 1ns / 1ps

module psc_verdict_checker
  import psc_pkg::*;
#(
  parameter int unsigned DEPTH_MAX = DEPTH_MAX_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] char_in
  input  logic       in_tlast,   // is_last
  input  logic       out_tvalid,
  input  logic       out_tready,
  input  logic [7:0] out_tdata,  // [0] valid_res, [7:1] zero
  output int         fail_count,
  output int         pending
);

  localparam int DW = $clog2(DEPTH_MAX + 1);

  logic [DW-1:0] sq_depth;
  logic [DW-1:0] rnd_depth;
  logic          esc_armed;
  logic [7:0]    last_nonblank;
  logic          seen_nonblank;
  logic          string_bad;
  logic          first_char;
  logic          verdict_q[$];
  logic          want;

  task automatic report(input string what);
    $display("MISMATCH at %0t ns: %s", $time, what);
    fail_count++;
  endtask

  task automatic restart_string();
    sq_depth      = '0;
    rnd_depth     = '0;
    esc_armed     = 1'b0;
    last_nonblank = 8'h00;
    seen_nonblank = 1'b0;
    string_bad    = 1'b0;
    first_char    = 1'b1;
  endtask

  // An open at the ceiling fails the string and leaves the depth where it is.
  function automatic logic [DW-1:0] deeper(input logic [DW-1:0] d);
    if (d >= DEPTH_MAX) begin
      string_bad = 1'b1;
      return d;
    end
    return d + 1'b1;
  endfunction

  // A close at depth zero fails the string; the depth stays at zero.
  function automatic logic [DW-1:0] shallower(input logic [DW-1:0] d);
    if (d == '0) begin
      string_bad = 1'b1;
      return d;
    end
    return d - 1'b1;
  endfunction

  task automatic fold_char(input logic [7:0] ch, input logic last);
    logic quant;
    quant = (ch == CH_STAR) || (ch == CH_PLUS) || (ch == CH_QUEST);
    if (ch == CH_NUL || ch == CH_FF)
      string_bad = 1'b1;
    if (first_char && last &&
        (ch == CH_DOLLAR || ch == CH_STAR || ch == CH_LSQ || ch == CH_RSQ || quant))
      string_bad = 1'b1;
    if (esc_armed) begin
      esc_armed = 1'b0;
    end else if (ch == CH_BSLASH && !last) begin
      esc_armed = 1'b1;
    end else begin
      if (ch == CH_LSQ)      sq_depth  = deeper(sq_depth);
      else if (ch == CH_RSQ) sq_depth  = shallower(sq_depth);
      else if (ch == CH_LPAR) rnd_depth = deeper(rnd_depth);
      else if (ch == CH_RPAR) rnd_depth = shallower(rnd_depth);
      if (quant && (!seen_nonblank || last_nonblank != CH_RPAR))
        string_bad = 1'b1;
    end
    if (ch != CH_SPACE && ch != CH_TAB) begin
      last_nonblank = ch;
      seen_nonblank = 1'b1;
    end
    first_char = 1'b0;
    if (last) begin
      verdict_q.push_back(!string_bad && sq_depth == '0 && rnd_depth == '0);
      restart_string();
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      restart_string();
      verdict_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (verdict_q.size() == 0) begin
          report($sformatf("verdict word 0x%02h with none predicted", out_tdata));
        end else begin
          want = verdict_q.pop_front();
          if (out_tdata[0] !== want)
            report($sformatf("valid_res %b, predicted %b", out_tdata[0], want));
          if (out_tdata[7:1] !== 7'd0)
            report($sformatf("padding bits of verdict word are 0x%02h", out_tdata[7:1]));
        end
      end
      if (in_tvalid && in_tready)
        fold_char(in_tdata, in_tlast);
    end
    pending = verdict_q.size();
  end

endmodule

// File: dv/tb_top.sv
// Top of the pattern syntax checker testbench: clock, reset, stimulus and the final verdict.
`timescale 1ns / 1ps

module tb_top;
  import psc_pkg::*;

  localparam int unsigned DEPTH_LIMIT = DEPTH_MAX_DEF;
  localparam int          WORD_TARGET = 1850;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;   // [7:0] char_in
  logic       in_tlast;   // is_last
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;  // [0] valid_res, [7:1] zero
  int         fail_count;
  int         pending;

  // Words queued for the next send, each held as {is_last, char_in}.
  logic [8:0] plan[$];
  int         words_sent = 0;
  // While calm is set neither side inserts any idle cycles.
  bit         calm = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  pattern_syntax_checker_unit #(
    .DEPTH_MAX(DEPTH_LIMIT)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  psc_verdict_checker #(
    .DEPTH_MAX(DEPTH_LIMIT)
  ) u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .fail_count(fail_count),
    .pending   (pending)
  );

  // Idle gaps are mostly absent or short, with the odd long one so that stalls land on every
  // phase of the block's two-stage pipeline.
  function automatic int idle_len();
    int r;
    if (calm)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // A byte drawn with weight on the characters that the checker treats specially. The wide
  // random share makes sure every bit of char_in is seen at both values.
  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return 8'($urandom_range(0, 255));
    if (r < 32) return 8'h61 + 8'($urandom_range(0, 25));
    case ($urandom_range(0, 12))
      0:       return CH_LPAR;
      1:       return CH_RPAR;
      2:       return CH_LSQ;
      3:       return CH_RSQ;
      4:       return CH_BSLASH;
      5:       return CH_STAR;
      6:       return CH_PLUS;
      7:       return CH_QUEST;
      8:       return CH_DOLLAR;
      9:       return CH_SPACE;
      10:      return CH_TAB;
      11:      return CH_NUL;
      default: return CH_FF;
    endcase
  endfunction

  function automatic logic [7:0] blank();
    return $urandom_range(0, 1) ? CH_SPACE : CH_TAB;
  endfunction

  task automatic put(input logic [7:0] ch, input logic last);
    plan.push_back({last, ch});
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++)
      put(s[i], i == s.len() - 1);
  endtask

  // Presents one word after a random gap and holds it until the block takes it. A valid that
  // stays high across back-to-back words is never dropped and raised in one step.
  task automatic send_word(input logic [8:0] w);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= w[7:0];
    in_tlast  <= w[8];
    do @(posedge clk); while (!in_tready);
    words_sent++;
  endtask

  task automatic send_plan();
    foreach (plan[i])
      send_word(plan[i]);
    plan.delete();
  endtask

  // Holds the sender off until every predicted verdict has come out.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Mostly well-formed patterns: groups and classes that close in order, escapes, blanks and
  // quantifiers after ')', so that the deeper rules are reached. The rest is noise, lone bytes
  // and well-formed patterns with one byte spoiled.
  task automatic build_pattern();
    logic [7:0] opens[$];
    int         r;
    int         tokens;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      repeat ($urandom_range(1, 10)) put(pick_char(), 1'b0);
    end else if (r < 16) begin
      put(pick_char(), 1'b0);
    end else begin
      tokens = $urandom_range(1, 12);
      repeat (tokens) begin
        r = $urandom_range(0, 99);
        if (r < 30) begin
          put(8'h61 + 8'($urandom_range(0, 25)), 1'b0);
        end else if (r < 45) begin
          opens.push_back($urandom_range(0, 1) ? CH_LPAR : CH_LSQ);
          put(opens[$], 1'b0);
        end else if (r < 65 && opens.size() != 0) begin
          if (opens.pop_back() == CH_LPAR) begin
            put(CH_RPAR, 1'b0);
            if ($urandom_range(0, 2) == 0) begin
              repeat ($urandom_range(0, 2)) put(blank(), 1'b0);
              case ($urandom_range(0, 2))
                0:       put(CH_STAR, 1'b0);
                1:       put(CH_PLUS, 1'b0);
                default: put(CH_QUEST, 1'b0);
              endcase
            end
          end else begin
            put(CH_RSQ, 1'b0);
          end
        end else if (r < 75) begin
          put(CH_BSLASH, 1'b0);
          put(pick_char(), 1'b0);
        end else if (r < 85) begin
          put(blank(), 1'b0);
        end else begin
          put($urandom_range(0, 1) ? CH_DOLLAR : pick_char(), 1'b0);
        end
      end
      while (opens.size() != 0)
        put(opens.pop_back() == CH_LPAR ? CH_RPAR : CH_RSQ, 1'b0);
      if (plan.size() == 0)
        put(8'h61, 1'b0);
      if ($urandom_range(0, 9) == 0)
        plan[$urandom_range(0, plan.size() - 1)][7:0] = pick_char();
    end
    plan[plan.size() - 1][8] = 1'b1;
  endtask

  // Nests one bracket kind to the given depth and closes it again. One step beyond the limit
  // drives the depth into saturation.
  task automatic build_deep(input int levels);
    logic [7:0] open_ch;
    logic [7:0] close_ch;
    open_ch  = $urandom_range(0, 1) ? CH_LPAR : CH_LSQ;
    close_ch = (open_ch == CH_LPAR) ? CH_RPAR : CH_RSQ;
    repeat (levels) put(open_ch, 1'b0);
    repeat (levels) put(close_ch, 1'b0);
    plan[plan.size() - 1][8] = 1'b1;
  endtask

  // The receiver stalls on its own schedule, independent of the sender.
  initial begin
    int hold;
    hold = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        out_tready <= 1'b0;
        hold--;
      end else begin
        out_tready <= 1'b1;
        hold = idle_len();
      end
    end
  end

  initial begin
    int idx;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= 8'h00;
    in_tlast  <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed strings: a plain byte, both forbidden bytes, every lone special character,
    // a quantifier after ')' across a space and a tab, a quantifier after a letter, a
    // backslash as the final byte, an escaped close, an underflow, brackets left open and an
    // escaped NUL.
    put_text("a");
    put(CH_NUL, 1'b1);
    put(CH_FF, 1'b1);
    put_text("*");
    put_text("$");
    put_text("[");
    put_text("]");
    put_text("+");
    put_text("?");
    put_text("(a) \t+");
    put_text("a*");
    put_text("\\");
    put_text("\\)");
    put_text(")");
    put_text("[(");
    put(CH_BSLASH, 1'b0);
    put(CH_NUL, 1'b1);
    send_plan();
    drain();

    // Random patterns, with a few calm stretches, one nesting exactly to the limit and one
    // nesting past it.
    idx = 0;
    while (words_sent < WORD_TARGET) begin
      calm = (idx % 40) < 5;
      if (idx == 25)
        build_deep(DEPTH_LIMIT);
      else if (idx == 50)
        build_deep(DEPTH_LIMIT + 1);
      else
        build_pattern();
      send_plan();
      if (idx == 120)
        drain();
      idx++;
    end
    calm = 1'b0;

    drain();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Far beyond the slowest correct run: every word waiting out the longest gap on both sides.
  initial begin
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
